### rtl/voxel_grid_ray_traversal_core_defines.svh
// Assertion macros shared by the checker of the voxel traversal core.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef VOXEL_GRID_RAY_TRAVERSAL_CORE_DEFINES_SVH
`define VOXEL_GRID_RAY_TRAVERSAL_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VGRT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("voxel traversal core check failed");

// The consequent must hold in the cycle after the antecedent.
`define VGRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("voxel traversal core check failed");

`endif

### rtl/vgrt_pkg.sv
// ----------------------------------------------------------------------------
// vgrt_pkg
// Shared sizes, codes and control types of the voxel traversal core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vgrt_pkg;

  localparam int COLUMNS_PER_SIDE = 2;
  localparam int COLUMN_WIDTH     = 16;
  localparam int HEIGHT           = 256;
  localparam int BLOCK_BITS       = 8;

  localparam int SPAN       = COLUMNS_PER_SIDE * COLUMN_WIDTH;
  localparam int BASE       = (COLUMNS_PER_SIDE / 2) * COLUMN_WIDTH;
  localparam int STORE_SIZE = SPAN * SPAN * HEIGHT;
  localparam int ADDR_W     = $clog2(STORE_SIZE);

  localparam int CMD_W   = 2;
  localparam int POS_W   = 32;
  localparam int FRAC_W  = 16;
  localparam int DIR_W   = 20;
  localparam int BLK_W   = 8;
  localparam int STEPS_W = 12;
  localparam int VOX_W   = 16;
  localparam int SIDE_W  = 2;
  localparam int COORD_W = 18;                 // voxel plus up to 4095 steps
  localparam int TIME_W  = STEPS_W + FRAC_W;   // times never exceed the cap
  localparam int QUO_W   = 33;                 // quotients up to 2^32
  localparam int NUM_W   = FRAC_W + 1;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TRACE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  localparam logic [1:0] MEM_IDLE  = 2'd0;
  localparam logic [1:0] MEM_CLEAR = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;
  localparam logic [1:0] MEM_READ  = 2'd3;

  localparam logic [1:0] RES_READ  = 2'd0;
  localparam logic [1:0] RES_START = 2'd1;
  localparam logic [1:0] RES_HIT   = 2'd2;
  localparam logic [1:0] RES_MISS  = 2'd3;

  localparam logic [SIDE_W-1:0] SIDE_X = 2'd0;
  localparam logic [SIDE_W-1:0] SIDE_Y = 2'd1;
  localparam logic [SIDE_W-1:0] SIDE_Z = 2'd2;

  // Six divisions per trace: delta then first boundary time, per axis.
  localparam logic [2:0] DIV_LAST = 3'd5;

  typedef struct packed {
    logic       in_ready;
    logic       load;
    logic [1:0] mem_op;
    logic       div_start;
    logic       div_load;
    logic       step;
    logic       res_load;
    logic [1:0] res_kind;
  } vgrt_cmd_t;

  typedef struct packed {
    logic             in_valid;
    logic             clr_last;
    logic [CMD_W-1:0] cmd;
    logic             solid;
    logic             div_done;
    logic             div_last;
    logic             steps_done;
    logic             prev_mode;
    logic             out_free;
  } vgrt_sts_t;

endpackage

`default_nettype wire

### rtl/vgrt_if.sv
// ----------------------------------------------------------------------------
// vgrt_in_if / vgrt_out_if
// Valid/ready channels carrying command beats and result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface vgrt_in_if;
  import vgrt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic signed [DIR_W-1:0]  dir_x;
  logic signed [DIR_W-1:0]  dir_y;
  logic signed [DIR_W-1:0]  dir_z;
  logic [BLK_W-1:0]         block_value;
  logic [STEPS_W-1:0]       max_steps;
  logic                     return_previous;

  modport source (output valid, cmd, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                  block_value, max_steps, return_previous, input ready);
  modport sink   (input valid, cmd, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                  block_value, max_steps, return_previous, output ready);
endinterface

interface vgrt_out_if;
  import vgrt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic signed [VOX_W-1:0]  vox_x;
  logic signed [VOX_W-1:0]  vox_y;
  logic signed [VOX_W-1:0]  vox_z;
  logic [SIDE_W-1:0]        side;
  logic [BLK_W-1:0]         read_value;

  modport source (output valid, hit, vox_x, vox_y, vox_z, side, read_value,
                  input ready);
  modport sink   (input valid, hit, vox_x, vox_y, vox_z, side, read_value,
                  output ready);
endinterface

`default_nettype wire

### rtl/vgrt_ram.sv
// ----------------------------------------------------------------------------
// vgrt_ram
// Generic single-port RAM with registered, enabled read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vgrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

### rtl/vgrt_div.sv
// ----------------------------------------------------------------------------
// vgrt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vgrt_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [vgrt_pkg::QUO_W-1:0]  num,
  input  wire logic [vgrt_pkg::DIR_W-1:0]  den,
  output logic                             done,
  output logic [vgrt_pkg::QUO_W-1:0]       quo
);
  import vgrt_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIR_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [DIR_W:0]   trial;
  logic             fits;

  // The dividend shifts out of the top of quo_r while quotient bits enter below.
  // A zero divisor yields all ones, which the caller clamps to its cap.
  assign trial = {rem_r, quo_r[QUO_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(QUO_W);
      rem_nxt  = '0;
      quo_nxt  = num;
    end else if (busy_r) begin
      rem_nxt = fits ? DIR_W'(trial - {1'b0, den}) : DIR_W'(trial);
      quo_nxt = {quo_r[QUO_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

### rtl/vgrt_datapath.sv
// ----------------------------------------------------------------------------
// vgrt_datapath
// Voxel store, ray state, boundary-time arithmetic and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vgrt_datapath (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire vgrt_pkg::vgrt_cmd_t cmd,
  output vgrt_pkg::vgrt_sts_t sts,
  vgrt_in_if.sink             in_bus,
  vgrt_out_if.source          out_bus
);
  import vgrt_pkg::*;

  localparam logic signed [COORD_W-1:0] STEP_UP = COORD_W'(1);
  localparam logic signed [COORD_W-1:0] STEP_DN = '1;
  localparam logic [QUO_W-1:0] DIV_ONE = {1'b1, {(QUO_W-1){1'b0}}};
  localparam logic [NUM_W-1:0] NUM_FULL = {1'b1, {FRAC_W{1'b0}}};

  function automatic logic vox_inside(input logic signed [COORD_W-1:0] x,
                                      input logic signed [COORD_W-1:0] y,
                                      input logic signed [COORD_W-1:0] z);
    logic signed [COORD_W:0] xo;
    logic signed [COORD_W:0] zo;
    xo = (COORD_W+1)'(x) + (COORD_W+1)'(BASE);
    zo = (COORD_W+1)'(z) + (COORD_W+1)'(BASE);
    return (xo >= 0) && (xo < (COORD_W+1)'(SPAN)) &&
           (zo >= 0) && (zo < (COORD_W+1)'(SPAN)) &&
           (y >= 0) && (y < (COORD_W)'(HEIGHT));
  endfunction

  // Columns are laid out x-major, then layer, then local x, then local z.
  function automatic logic [ADDR_W-1:0] vox_addr(input logic signed [COORD_W-1:0] x,
                                                 input logic signed [COORD_W-1:0] y,
                                                 input logic signed [COORD_W-1:0] z);
    logic [ADDR_W-1:0] ux;
    logic [ADDR_W-1:0] uy;
    logic [ADDR_W-1:0] uz;
    ux = ADDR_W'(x + COORD_W'(BASE));
    uy = ADDR_W'(y);
    uz = ADDR_W'(z + COORD_W'(BASE));
    return ADDR_W'((((ux / COLUMN_WIDTH) * COLUMNS_PER_SIDE + uz / COLUMN_WIDTH)
                    * HEIGHT + uy) * COLUMN_WIDTH * COLUMN_WIDTH
                   + (ux % COLUMN_WIDTH) * COLUMN_WIDTH + uz % COLUMN_WIDTH);
  endfunction

  // Latched beat.
  logic [CMD_W-1:0]         cmd_r;
  logic [BLK_W-1:0]         blk_r;
  logic [STEPS_W-1:0]       max_r;
  logic                     prev_r;
  logic [TIME_W-1:0]        cap_r;
  logic signed [DIR_W-1:0]  dir_r   [3];
  logic [FRAC_W-1:0]        frac_r  [3];

  // Traversal state.
  logic signed [COORD_W-1:0] vox_r  [3];
  logic signed [COORD_W-1:0] last_r [3];
  logic [TIME_W-1:0]         next_r [3];
  logic [TIME_W-1:0]         delta_r[3];
  logic [STEPS_W-1:0]        n_r;
  logic [SIDE_W-1:0]         side_r;
  logic [2:0]                div_idx_r;
  logic                      in_range_r;
  logic [ADDR_W-1:0]         clr_cnt_r;

  // Result register.
  logic                      out_valid_r;
  logic                      hit_r;
  logic signed [VOX_W-1:0]   ox_r, oy_r, oz_r;
  logic [SIDE_W-1:0]         oside_r;
  logic [BLK_W-1:0]          oval_r;
  logic                      hit_nxt;
  logic signed [VOX_W-1:0]   ox_nxt, oy_nxt, oz_nxt;
  logic [SIDE_W-1:0]         oside_nxt;
  logic [BLK_W-1:0]          oval_nxt;

  logic [BLOCK_BITS-1:0] rdata;
  logic [ADDR_W-1:0]     mem_addr;
  logic                  mem_we;
  logic                  mem_re;
  logic [BLOCK_BITS-1:0] mem_wdata;
  logic                  cur_inside;

  logic [1:0]        div_axis;
  logic [QUO_W-1:0]  div_num;
  logic [NUM_W-1:0]  bound_num;
  logic [DIR_W-1:0]  div_den;
  logic              div_done;
  logic [QUO_W-1:0]  div_quo;
  logic [TIME_W-1:0] quo_sat;

  logic [1:0]             pick;
  logic [TIME_W:0]        adv_sum;
  logic [TIME_W-1:0]      adv_time;
  logic signed [COORD_W-1:0] adv_step;

  assign cur_inside = vox_inside(vox_r[0], vox_r[1], vox_r[2]);

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = vox_addr(vox_r[0], vox_r[1], vox_r[2]);
    mem_wdata = BLOCK_BITS'(blk_r);
    unique case (cmd.mem_op)
      MEM_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_r;
        mem_wdata = '0;
      end
      MEM_WRITE: mem_we = cur_inside;
      MEM_READ:  mem_re = 1'b1;
      default:   mem_we = 1'b0;
    endcase
  end

  vgrt_ram #(
    .WIDTH (BLOCK_BITS),
    .DEPTH (STORE_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (rdata)
  );

  // Division operands: even index is the per-axis delta, odd the first boundary.
  assign div_axis  = div_idx_r[2:1];
  assign bound_num = dir_r[div_axis][DIR_W-1] ? {1'b0, frac_r[div_axis]}
                                              : NUM_FULL - {1'b0, frac_r[div_axis]};
  assign div_num   = div_idx_r[0] ? {bound_num, {FRAC_W{1'b0}}} : DIV_ONE;
  assign div_den   = dir_r[div_axis][DIR_W-1] ? DIR_W'(-dir_r[div_axis])
                                              : DIR_W'(dir_r[div_axis]);

  vgrt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign quo_sat = (div_quo < QUO_W'(cap_r)) ? TIME_W'(div_quo) : cap_r;

  // Axis with the smallest next boundary; the lower axis wins a tie.
  always_comb begin
    pick = SIDE_X;
    if (next_r[0] > next_r[1]) begin
      pick = SIDE_Y;
    end
    if (next_r[pick] > next_r[2]) begin
      pick = SIDE_Z;
    end
  end

  assign adv_sum  = {1'b0, next_r[pick]} + {1'b0, delta_r[pick]};
  assign adv_time = (adv_sum < {1'b0, cap_r}) ? TIME_W'(adv_sum) : cap_r;
  assign adv_step = (dir_r[pick] == '0) ? '0 :
                    (dir_r[pick][DIR_W-1] ? STEP_DN : STEP_UP);

  // Misses report all-ones coordinates unless a result kind says otherwise.
  always_comb begin
    hit_nxt   = 1'b0;
    ox_nxt    = '1;
    oy_nxt    = '1;
    oz_nxt    = '1;
    oside_nxt = SIDE_X;
    oval_nxt  = '0;
    unique case (cmd.res_kind)
      RES_READ: begin
        ox_nxt   = '0;
        oy_nxt   = '0;
        oz_nxt   = '0;
        oval_nxt = in_range_r ? BLK_W'(rdata) : '0;
      end
      RES_START: begin
        if (!prev_r) begin
          hit_nxt = 1'b1;
          ox_nxt  = VOX_W'(vox_r[0]);
          oy_nxt  = VOX_W'(vox_r[1]);
          oz_nxt  = VOX_W'(vox_r[2]);
        end
      end
      RES_HIT: begin
        hit_nxt   = 1'b1;
        oside_nxt = side_r;
        ox_nxt    = VOX_W'(prev_r ? last_r[0] : vox_r[0]);
        oy_nxt    = VOX_W'(prev_r ? last_r[1] : vox_r[1]);
        oz_nxt    = VOX_W'(prev_r ? last_r[2] : vox_r[2]);
      end
      default: hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      div_idx_r   <= '0;
    end else begin
      if (cmd.mem_op == MEM_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load) begin
        div_idx_r <= '0;
      end else if (cmd.div_load) begin
        div_idx_r <= div_idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= in_bus.cmd;
      blk_r     <= in_bus.block_value;
      max_r     <= in_bus.max_steps;
      prev_r    <= in_bus.return_previous;
      cap_r     <= {in_bus.max_steps, {FRAC_W{1'b0}}};
      dir_r[0]  <= in_bus.dir_x;
      dir_r[1]  <= in_bus.dir_y;
      dir_r[2]  <= in_bus.dir_z;
      frac_r[0] <= in_bus.pos_x[FRAC_W-1:0];
      frac_r[1] <= in_bus.pos_y[FRAC_W-1:0];
      frac_r[2] <= in_bus.pos_z[FRAC_W-1:0];
      vox_r[0]  <= COORD_W'(in_bus.pos_x >>> FRAC_W);
      vox_r[1]  <= COORD_W'(in_bus.pos_y >>> FRAC_W);
      vox_r[2]  <= COORD_W'(in_bus.pos_z >>> FRAC_W);
      n_r       <= '0;
    end
    if (cmd.mem_op == MEM_READ) begin
      in_range_r <= cur_inside;
    end
    if (cmd.div_load) begin
      if (div_idx_r[0]) begin
        next_r[div_axis] <= quo_sat;
      end else begin
        delta_r[div_axis] <= quo_sat;
      end
    end
    if (cmd.step) begin
      last_r         <= vox_r;
      next_r[pick]   <= adv_time;
      vox_r[pick]    <= vox_r[pick] + adv_step;
      side_r         <= pick;
      n_r            <= n_r + STEPS_W'(1);
    end
    if (cmd.res_load) begin
      hit_r   <= hit_nxt;
      ox_r    <= ox_nxt;
      oy_r    <= oy_nxt;
      oz_r    <= oz_nxt;
      oside_r <= oside_nxt;
      oval_r  <= oval_nxt;
    end
  end

  assign in_bus.ready       = cmd.in_ready;
  assign out_bus.valid      = out_valid_r;
  assign out_bus.hit        = hit_r;
  assign out_bus.vox_x      = ox_r;
  assign out_bus.vox_y      = oy_r;
  assign out_bus.vox_z      = oz_r;
  assign out_bus.side       = oside_r;
  assign out_bus.read_value = oval_r;

  assign sts.in_valid   = in_bus.valid;
  assign sts.clr_last   = clr_cnt_r == ADDR_W'(STORE_SIZE - 1);
  assign sts.cmd        = cmd_r;
  assign sts.solid      = in_range_r && (rdata != '0);
  assign sts.div_done   = div_done;
  assign sts.div_last   = div_idx_r == DIV_LAST;
  assign sts.steps_done = n_r == max_r;
  assign sts.prev_mode  = prev_r;
  assign sts.out_free   = !out_valid_r || out_bus.ready;

endmodule

`default_nettype wire

### rtl/vgrt_ctrl.sv
// ----------------------------------------------------------------------------
// vgrt_ctrl
// Sequencer for store clearing, voxel access, divisions and ray stepping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vgrt_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire vgrt_pkg::vgrt_sts_t sts,
  output vgrt_pkg::vgrt_cmd_t      cmd
);
  import vgrt_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DISP = 4'd2;
  localparam logic [3:0] S_WR   = 4'd3;
  localparam logic [3:0] S_LOOK = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_DIVW = 4'd7;
  localparam logic [3:0] S_TEST = 4'd8;
  localparam logic [3:0] S_STEP = 4'd9;
  localparam logic [3:0] S_RES  = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       walking_r, walking_nxt;
  logic [1:0] kind_r, kind_nxt;

  always_comb begin
    state_nxt   = state_r;
    walking_nxt = walking_r;
    kind_nxt    = kind_r;
    cmd         = '0;
    cmd.mem_op  = MEM_IDLE;
    unique case (state_r)
      S_CLR: begin
        cmd.mem_op = MEM_CLEAR;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.load    = 1'b1;
          walking_nxt = 1'b0;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.cmd)
          CMD_WRITE: state_nxt = S_WR;
          CMD_READ:  state_nxt = S_LOOK;
          CMD_TRACE: state_nxt = S_LOOK;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_WR: begin
        cmd.mem_op = MEM_WRITE;
        state_nxt  = S_IDLE;
      end
      S_LOOK: begin
        cmd.mem_op = MEM_READ;
        state_nxt  = S_CHK;
      end
      S_CHK: begin
        if (sts.cmd == CMD_READ) begin
          kind_nxt  = RES_READ;
          state_nxt = S_RES;
        end else if (sts.solid) begin
          kind_nxt  = walking_r ? RES_HIT : RES_START;
          state_nxt = S_RES;
        end else begin
          state_nxt = walking_r ? S_TEST : S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) begin
          cmd.div_load = 1'b1;
          if (sts.div_last) begin
            walking_nxt = 1'b1;
            state_nxt   = S_TEST;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_TEST: begin
        if (sts.steps_done) begin
          kind_nxt  = RES_MISS;
          state_nxt = S_RES;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_LOOK;
      end
      S_RES: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
    cmd.res_kind = kind_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      walking_r <= 1'b0;
      kind_r    <= RES_READ;
    end else begin
      state_r   <= state_nxt;
      walking_r <= walking_nxt;
      kind_r    <= kind_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/voxel_grid_ray_traversal_core.sv
// Sequence: a write passes dispatch and the store write before the input is
// free again; a read passes dispatch, store lookup, check and result register;
// a trace does its first lookup, six divisions on the shared divider, then a
// test, step, lookup and check per voxel step. One beat is taken at a time.
// Reset: synchronous active low; afterwards a clearing pass writes all
// STORE_SIZE voxels before the first beat is taken.
// ----------------------------------------------------------------------------
// voxel_grid_ray_traversal_core
// Voxel store with fixed-point grid ray traversal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module voxel_grid_ray_traversal_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  vgrt_in_if.sink    in_bus,
  vgrt_out_if.source out_bus
);
  import vgrt_pkg::*;

  vgrt_cmd_t cmd;
  vgrt_sts_t sts;

  vgrt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  vgrt_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

endmodule

`default_nettype wire

### rtl/vgrt_checker.sv
// ----------------------------------------------------------------------------
// vgrt_checker
// Port-level checks of the voxel traversal core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "voxel_grid_ray_traversal_core_defines.svh"

module vgrt_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_hit,
  input wire logic [1:0] out_side,
  input wire logic [7:0] out_read_value
);

  // A result waits until it is taken.
  `VGRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // Ready drops after an accept, since the accepted beat leaves the idle state.
  `VGRT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // Misses and reads always report the x side.
  `VGRT_ASSERT_SAME(a_side_on_miss, out_valid && !out_hit, out_side == 2'd0)
  // Traces never carry a read value.
  `VGRT_ASSERT_SAME(a_hit_no_value, out_valid && out_hit, out_read_value == 8'd0)

endmodule

bind voxel_grid_ray_traversal_core vgrt_checker u_vgrt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_bus.valid),
  .in_ready       (in_bus.ready),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .out_hit        (out_bus.hit),
  .out_side       (out_bus.side),
  .out_read_value (out_bus.read_value)
);

`default_nettype wire
